### hdl/xoshiro_pkg.sv
// ----------------------------------------------------------------------------
// xoshiro_pkg
// Shared widths, constants and controller/datapath command types for the
// xoshiro256+ generator with splitmix64 seeding.
// ----------------------------------------------------------------------------
`default_nettype none

package xoshiro_pkg;

  localparam int WORD_W   = 64;
  localparam int HALF_W   = 32;
  localparam int FRAC_W   = 53;
  localparam int INT_W    = 32;
  localparam int NWORDS   = 4;
  localparam int IDX_W    = 2;
  localparam int OUT_W    = FRAC_W + INT_W;
  localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  localparam int SHL_T   = 17;
  localparam int ROT_L   = 45;
  localparam int FRAC_SH = 11;
  localparam int MIX_SH0 = 30;
  localparam int MIX_SH1 = 27;
  localparam int MIX_SH2 = 31;

  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_DRAW,
    OP_PRE,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_XOR27,
    OP_WRITE
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic             use_b;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

endpackage

`default_nettype wire

### hdl/xoshiro256plus_generator.sv
// ----------------------------------------------------------------------------
// xoshiro256plus_generator
// Draws: a draw gives its result in the cycle after the transfer; draws run at
// one per cycle while no seeding runs and the result register is free or
// being taken. Reseed: loads the seed, then seeds all 4 words through the
// single shared 32x32 multiplier that forms each splitmix64 product in four
// steps. Reset: synchronous; the state is then seeded with zero by the same
// sequence, during which s_tready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module xoshiro256plus_generator
  import xoshiro_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [WORD_W-1:0]   s_tdata,   // seed_value
  input  wire logic                s_tuser,   // command
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic      [M_DATA_W-1:0] m_tdata    // fraction_bits, word32, zero pad
);

  dp_cmd_t          cmd;
  logic [FRAC_W-1:0] fraction_bits;
  logic [INT_W-1:0]  word32;

  xoshiro_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_command (s_tuser),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .cmd        (cmd)
  );

  xoshiro_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .seed_value    (s_tdata),
    .fraction_bits (fraction_bits),
    .word32        (word32)
  );

  assign m_tdata = {{(M_DATA_W - OUT_W){1'b0}}, word32, fraction_bits};

endmodule

`default_nettype wire

### hdl/xoshiro_dp.sv
// ----------------------------------------------------------------------------
// xoshiro_dp
// Datapath: four state words, splitmix64 unit with one shared 32x32
// multiplier, xoshiro256+ step and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module xoshiro_dp
  import xoshiro_pkg::*;
(
  input  wire logic              clk,
  input  wire dp_cmd_t           cmd,
  input  wire logic [WORD_W-1:0] seed_value,
  output logic      [FRAC_W-1:0] fraction_bits,
  output logic      [INT_W-1:0]  word32
);

  logic [WORD_W-1:0] gen_words [NWORDS];
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] z;
  logic [WORD_W-1:0] res;
  logic [WORD_W-1:0] prod;

  logic [WORD_W-1:0] acc_inc;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] mul_c;
  logic [HALF_W-1:0] mul_x;
  logic [HALF_W-1:0] mul_y;
  logic [WORD_W-1:0] prod_c;
  logic [WORD_W-1:0] t_shl;
  logic [WORD_W-1:0] n0, n1, n2, n3;

  assign acc_inc = acc + GOLDEN_STEP;
  assign sum     = gen_words[0] + gen_words[3];
  assign mul_c   = cmd.use_b ? MIX_MUL_B : MIX_MUL_A;

  // low x low, high x low, low x high; the high x high term falls off mod 2^64
  always_comb begin
    mul_x = z[HALF_W-1:0];
    mul_y = mul_c[HALF_W-1:0];
    case (cmd.op)
      OP_MUL1: begin
        mul_x = z[WORD_W-1:HALF_W];
      end
      OP_MUL2: begin
        mul_y = mul_c[WORD_W-1:HALF_W];
      end
      default: begin
      end
    endcase
  end

  // zero-extended operands, still a 32x32 product
  assign prod_c = WORD_W'(mul_x) * WORD_W'(mul_y);

  assign t_shl = gen_words[1] << SHL_T;
  assign n2    = gen_words[2] ^ gen_words[0];
  assign n3    = gen_words[3] ^ gen_words[1];
  assign n1    = gen_words[1] ^ n2;
  assign n0    = gen_words[0] ^ n3;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CLEAR: begin
        acc <= '0;
      end
      OP_LOAD: begin
        acc <= seed_value;
      end
      OP_DRAW: begin
        fraction_bits <= sum[WORD_W-1:FRAC_SH];
        word32        <= sum[WORD_W-1:WORD_W-INT_W];
        gen_words[0]  <= n0;
        gen_words[1]  <= n1;
        gen_words[2]  <= n2 ^ t_shl;
        gen_words[3]  <= {n3[WORD_W-ROT_L-1:0], n3[WORD_W-1:WORD_W-ROT_L]};
      end
      OP_PRE: begin
        acc <= acc_inc;
        z   <= acc_inc ^ (acc_inc >> MIX_SH0);
      end
      OP_MUL0: begin
        prod <= prod_c;
      end
      OP_MUL1: begin
        prod <= prod_c;
        res  <= prod;
      end
      OP_MUL2: begin
        prod                <= prod_c;
        res[WORD_W-1:HALF_W] <= res[WORD_W-1:HALF_W] + prod[HALF_W-1:0];
      end
      OP_MUL3: begin
        res[WORD_W-1:HALF_W] <= res[WORD_W-1:HALF_W] + prod[HALF_W-1:0];
      end
      OP_XOR27: begin
        z <= res ^ (res >> MIX_SH1);
      end
      OP_WRITE: begin
        gen_words[cmd.idx] <= res ^ (res >> MIX_SH2);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/xoshiro_ctrl.sv
// ----------------------------------------------------------------------------
// xoshiro_ctrl
// Controller: input handshake, seeding sequence and result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module xoshiro_ctrl
  import xoshiro_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_command,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output dp_cmd_t   cmd
);

  typedef enum logic [8:0] {
    S_INIT = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_PRE  = 9'b000000100,
    S_M0   = 9'b000001000,
    S_M1   = 9'b000010000,
    S_M2   = 9'b000100000,
    S_M3   = 9'b001000000,
    S_X27  = 9'b010000000,
    S_WR   = 9'b100000000
  } state_t;

  state_t           state, state_next;
  logic             use_b, use_b_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             out_valid_next;
  logic             in_xfer;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    use_b_next     = use_b;
    idx_next       = idx;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = OP_NONE;
    cmd.use_b      = use_b;
    cmd.idx        = idx;
    case (state)
      S_INIT: begin
        cmd.op     = OP_CLEAR;
        idx_next   = '0;
        use_b_next = 1'b0;
        state_next = S_PRE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (in_command == CMD_RESEED) begin
            cmd.op     = OP_LOAD;
            idx_next   = '0;
            use_b_next = 1'b0;
            state_next = S_PRE;
          end else begin
            cmd.op         = OP_DRAW;
            out_valid_next = 1'b1;
          end
        end
      end
      S_PRE: begin
        cmd.op     = OP_PRE;
        state_next = S_M0;
      end
      S_M0: begin
        cmd.op     = OP_MUL0;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.op     = OP_MUL1;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.op     = OP_MUL2;
        state_next = S_M3;
      end
      S_M3: begin
        cmd.op     = OP_MUL3;
        state_next = use_b ? S_WR : S_X27;
      end
      S_X27: begin
        cmd.op     = OP_XOR27;
        use_b_next = 1'b1;
        state_next = S_M0;
      end
      S_WR: begin
        cmd.op     = OP_WRITE;
        use_b_next = 1'b0;
        idx_next   = idx + IDX_W'(1);
        state_next = (idx == IDX_W'(NWORDS - 1)) ? S_IDLE : S_PRE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      use_b     <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      use_b     <= use_b_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

### hdl/xoshiro_checker.sv
// ----------------------------------------------------------------------------
// xoshiro_checker
// Port-level checks on the generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xoshiro_checker
  import xoshiro_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic                s_tuser,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata
);

  logic in_xfer;
  assign in_xfer = s_tvalid && s_tready;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("output valid or input ready straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_draw_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (s_tuser == CMD_DRAW) |=> m_tvalid)
    else $error("draw transfer gave no result");

  a_reseed_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (s_tuser == CMD_RESEED) |=> !s_tready && !$rose(m_tvalid))
    else $error("reseed not followed by seeding sequence");

  a_word_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[FRAC_W-1:FRAC_W-INT_W] == m_tdata[OUT_W-1:FRAC_W])
    else $error("word32 differs from top of fraction");

endmodule

bind xoshiro256plus_generator xoshiro_checker u_xoshiro_checker (.*);

`default_nettype wire

### tb/xoshiro256plus_generator_test.sv
// ----------------------------------------------------------------------------
// xoshiro256plus_generator_test
// Stream testbench for the xoshiro256+ generator with splitmix64 seeding.
// Draw and reseed commands go in on the slave side. A scoreboard class keeps
// its own copy of the four state words and predicts each draw result. Results
// on the master side are checked field by field against the oldest
// prediction. The random part runs in phases of sender idling and receiver
// stalling, and one phase includes a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module xoshiro256plus_generator_test;
  import xoshiro_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 8;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 350;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [FRAC_W-1:0] fraction_bits;
    logic [INT_W-1:0]  word32;
  } draw_t;

  class rng_scoreboard;
    logic [WORD_W-1:0] gen_state [NWORDS];
    draw_t             expected_draws [$];
    int                errors;

    function new();
      errors = 0;
      seed_state('0);
    endfunction

    function logic [WORD_W-1:0] splitmix_next(inout logic [WORD_W-1:0] acc);
      logic [WORD_W-1:0] z;
      acc = acc + GOLDEN_STEP;
      z = acc;
      z = (z ^ (z >> MIX_SH0)) * MIX_MUL_A;
      z = (z ^ (z >> MIX_SH1)) * MIX_MUL_B;
      return z ^ (z >> MIX_SH2);
    endfunction

    function void seed_state(logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] acc;
      acc = seed;
      for (int i = 0; i < NWORDS; i++) gen_state[i] = splitmix_next(acc);
    endfunction

    function void note_command(logic cmd, logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] t;
      draw_t             d;
      if (cmd == CMD_RESEED) begin
        seed_state(seed);
        return;
      end
      sum = gen_state[0] + gen_state[3];
      t = gen_state[1] << SHL_T;
      gen_state[2] ^= gen_state[0];
      gen_state[3] ^= gen_state[1];
      gen_state[1] ^= gen_state[2];
      gen_state[0] ^= gen_state[3];
      gen_state[2] ^= t;
      gen_state[3] = {gen_state[3][WORD_W-ROT_L-1:0], gen_state[3][WORD_W-1:WORD_W-ROT_L]};
      d.fraction_bits = sum[WORD_W-1:FRAC_SH];
      d.word32 = sum[WORD_W-1:HALF_W];
      expected_draws = {expected_draws, d};
    endfunction

    function void check_draw(logic [M_DATA_W-1:0] data);
      draw_t d;
      if (expected_draws.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      d = expected_draws.pop_front();
      if (data[FRAC_W-1:0] !== d.fraction_bits) begin
        $display("%0t: fraction_bits expected %h, got %h", $time, d.fraction_bits,
                 data[FRAC_W-1:0]);
        errors++;
      end
      if (data[FRAC_W +: INT_W] !== d.word32) begin
        $display("%0t: word32 expected %h, got %h", $time, d.word32,
                 data[FRAC_W +: INT_W]);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [WORD_W-1:0]   s_tdata = '0;
  logic                s_tuser = CMD_DRAW;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  rng_scoreboard sb = new();
  int            send_idle_pct = 0;
  int            rx_stall_pct = 0;
  logic          hold_rx = 1'b0;
  int            quiet_cycles = 0;

  xoshiro256plus_generator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(negedge clk) begin
    m_tready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_draw(m_tdata);
  end

  // watchdog: cycles without any transfer on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task send_command(input logic cmd, input logic [WORD_W-1:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= seed;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_command(cmd, seed);
    @(negedge clk);
  endtask

  function logic [WORD_W-1:0] pick_seed();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return 64'h1 << $urandom_range(WORD_W - 1);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task send_random(input int count);
    logic cmd;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(99) < 8) ? CMD_RESEED : CMD_DRAW;
      send_command(cmd, pick_seed());
    end
  endtask

  task send_directed();
    send_command(CMD_DRAW, '0);
    send_command(CMD_DRAW, '1);
    send_command(CMD_DRAW, 64'h5555_5555_5555_5555);
    send_command(CMD_RESEED, '0);
    send_command(CMD_DRAW, '0);
    send_command(CMD_DRAW, 64'haaaa_aaaa_aaaa_aaaa);
    send_command(CMD_RESEED, '1);
    send_command(CMD_DRAW, '0);
    send_command(CMD_DRAW, '0);
    send_command(CMD_RESEED, 64'h1);
    send_command(CMD_DRAW, '1);
    send_command(CMD_RESEED, 64'h8000_0000_0000_0000);
    send_command(CMD_DRAW, '0);
    send_command(CMD_RESEED, 64'haaaa_aaaa_aaaa_aaaa);
    send_command(CMD_DRAW, '0);
    send_command(CMD_RESEED, 64'h5555_5555_5555_5555);
    send_command(CMD_DRAW, '0);
    send_command(CMD_RESEED, 64'h0123_4567_89ab_cdef);
    send_command(CMD_RESEED, 64'hfedc_ba98_7654_3210);
    send_command(CMD_DRAW, '0);
    send_command(CMD_DRAW, '0);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_directed();

    // no idling, with a long receiver hold-off to back up the input
    send_idle_pct = 0;
    rx_stall_pct = 0;
    fork
      send_random(PHASE_ITEMS);
      begin
        repeat (40) @(posedge clk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
    join

    send_idle_pct = 59;
    rx_stall_pct = 0;
    send_random(PHASE_ITEMS);

    send_idle_pct = 0;
    rx_stall_pct = 59;
    send_random(PHASE_ITEMS);

    send_idle_pct = 29;
    rx_stall_pct = 29;
    send_random(PHASE_ITEMS);

    s_tvalid <= 1'b0;
    while (sb.expected_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
